@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Holds the command codes, controller states and channel payload structs.
// No dependencies.
package tcw_pkg;

  // Field widths of the channel payloads
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0]        COLOR_RESET  = 8'd7;

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } tcw_cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_POST
  } tcw_state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic [CELL_W-1:0] cell_data;
  } tcw_out_t;

endpackage

@@ rtl/core/tcw_cell_store.sv @@
// Screen cell store: one write port and one registered read port.
// Simple dual-port synchronous memory; depends on tcw_pkg for the cell width.
module tcw_cell_store #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // Write one cell
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one cell, data on the next cycle; hold while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) with a cursor.
// Channels: in_valid/in_ready/in_data carries commands (put character, clear
// screen, read cell); out_valid/out_ready/out_data returns one result per
// command with the cursor position after it and, for a read, the cell.
// cfg_we/cfg_wdata writes the current text color at any clock edge.
// Rows live in the cell store as a ring with a base row pointer, so a scroll
// moves the base and rewrites only the new bottom row.
// Command flow: a command is taken in the idle state, where a put of a
// character writes its cell and an in-range read issues its store read; a put
// that scrolls then blanks the new bottom row in the fill state (one store
// write per cell of the row), and clear so blanks all ROWS*COLUMNS cells.
// The result state loads the output register as it returns to idle.
// Reset: a clearing pass writes zero to all ROWS*COLUMNS cells, one per
// cycle, while in_ready stays low; cursor goes home and color becomes 7.
// Receiver stall: a waiting result sits in the output register while the next
// command is taken; a finished command then waits for that register to free.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tcw_pkg::tcw_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [ROW_W:0]   ROWS_E    = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]   COLS_E    = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  tcw_state_t state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [7:0]        color_r, color_nxt;
  logic [AW-1:0]     fill_addr_r, fill_addr_nxt;
  logic [AW-1:0]     fill_last_r, fill_last_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_data_r, out_data_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_q;

  logic              in_xfer, out_free, fill_done;
  logic              wrap, scroll, rd_in_range;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [AW-1:0]     cursor_addr, read_addr, base_addr;

  // Map a logical row onto the ring and form the cell address
  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                              input logic [COL_W-1:0] col,
                                              input logic [ROW_W-1:0] base);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum  = {1'b0, row} + {1'b0, base};
    prow = (sum >= ROWS_E) ? ROW_W'(sum - ROWS_E) : sum[ROW_W-1:0];
    return AW'(prow) * COLS_A + AW'(col);
  endfunction

  assign in_xfer   = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign fill_done = (fill_addr_r == fill_last_r);

  // Cursor advance for a put
  assign col_inc = {1'b0, col_r} + (COL_W + 1)'(1);
  assign row_inc = {1'b0, row_r} + (ROW_W + 1)'(1);
  assign wrap    = (in_data.char_code == NEWLINE_CODE) || (col_inc >= COLS_E);
  assign scroll  = wrap && (row_inc >= ROWS_E);

  assign cursor_addr = cell_addr(row_r, col_r, base_r);
  assign read_addr   = cell_addr(in_data.read_row, in_data.read_col, base_r);
  assign base_addr   = AW'(base_r) * COLS_A;
  assign rd_in_range = ({1'b0, in_data.read_row} < ROWS_E) &&
                       ({1'b0, in_data.read_col} < COLS_E);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (fill_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.cmd)
            CMD_PUT:   state_nxt = scroll ? ST_FILL : ST_POST;
            CMD_CLEAR: state_nxt = ST_FILL;
            default:   state_nxt = ST_POST;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_done) state_nxt = ST_POST;
      end
      ST_POST: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Store accesses, cursor, fill sweep and result register
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    color_nxt     = cfg_we ? cfg_wdata : color_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_addr_r;
    mem_wdata     = {color_r, SPACE_CODE};
    mem_re        = 1'b0;
    mem_raddr     = read_addr;
    case (state_r)
      ST_INIT: begin
        // Zero the store one cell a cycle
        mem_we        = 1'b1;
        mem_wdata     = '0;
        fill_addr_nxt = fill_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          rd_hit_nxt = 1'b0;
          case (in_data.cmd)
            CMD_PUT: begin
              if (in_data.char_code != NEWLINE_CODE) begin
                mem_we    = 1'b1;
                mem_waddr = cursor_addr;
                mem_wdata = {color_r, in_data.char_code};
              end
              if (!wrap) begin
                col_nxt = col_inc[COL_W-1:0];
              end else begin
                col_nxt = '0;
                if (scroll) begin
                  // Old top row becomes the new bottom row
                  row_nxt       = LAST_ROW;
                  base_nxt      = (base_r == LAST_ROW) ? '0 : base_r + ROW_W'(1);
                  fill_addr_nxt = base_addr;
                  fill_last_nxt = base_addr + COLS_A - AW'(1);
                end else begin
                  row_nxt = row_inc[ROW_W-1:0];
                end
              end
            end
            CMD_CLEAR: begin
              row_nxt       = '0;
              col_nxt       = '0;
              fill_addr_nxt = '0;
              fill_last_nxt = LAST_CELL;
            end
            CMD_READ: begin
              mem_re     = rd_in_range;
              rd_hit_nxt = rd_in_range;
            end
            default: begin
              rd_hit_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_FILL: begin
        // Blank one cell a cycle with the current color
        mem_we        = 1'b1;
        fill_addr_nxt = fill_addr_r + AW'(1);
      end
      ST_POST: begin
        // Load the result once the output register is free
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.cursor_row_out   = row_r;
          out_data_nxt.cursor_col_out   = col_r;
          out_data_nxt.cell_data        = rd_hit_r ? mem_q : '0;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      color_r     <= COLOR_RESET;
      fill_addr_r <= '0;
      fill_last_r <= LAST_CELL;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      color_r     <= color_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      rd_hit_r    <= rd_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcw_cell_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for text_console_writer: directed table, then random command streams.
// Checks each result against a scoreboard model of the screen, cursor and text color.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS_N      = 25;
  localparam int CELLS       = COLS * ROWS_N;
  localparam int PHASE_ITEMS = 155;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_CAP  = 100;

  typedef struct {
    tcw_in_t  item;
    int       reps;
    bit       typed;
    tcw_out_t want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tcw_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tcw_out_t out_data;
  logic     cfg_we;
  logic [7:0] cfg_wdata;

  // Scoreboard copy of the console
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [7:0]        cur_color;

  tcw_out_t  result_q [$];
  tcw_in_t   cmd_stream [$];
  dir_row_t  dir_table [$];
  int        err_count;
  int        cycle_count;
  int        burst_left;
  bit        tx_steady;
  bit        rx_steady;
  bit        rx_stall;
  int        rx_left;
  tcw_out_t  mon_want;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    if (err_count < REPORT_CAP) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Move the cursor to the start of the next row, scrolling at the bottom
  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS_N) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {cur_color, SPACE_CODE};
      cur_row = ROWS_N - 1;
    end
  endfunction

  // Apply one command to the scoreboard and return the result it yields
  function automatic tcw_out_t console_step(input tcw_in_t item);
    tcw_out_t res;
    res = '0;
    case (item.cmd)
      CMD_PUT: begin
        if (item.char_code == NEWLINE_CODE) begin
          advance_line();
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {cur_color, item.char_code};
          cur_col++;
          if (cur_col >= COLS) advance_line();
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {cur_color, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        if (item.read_row < ROWS_N && item.read_col < COLS)
          res.cell_data = shadow_screen[item.read_row * COLS + item.read_col];
      end
      default: ;
    endcase
    res.cursor_row_out = ROW_W'(cur_row);
    res.cursor_col_out = COL_W'(cur_col);
    return res;
  endfunction

  function automatic tcw_in_t mk_cmd(input tcw_cmd_t cmd, input logic [7:0] ch,
                                     input logic [4:0] r, input logic [6:0] c);
    tcw_in_t it;
    it.cmd       = cmd;
    it.char_code = ch;
    it.read_row  = r;
    it.read_col  = c;
    return it;
  endfunction

  function automatic tcw_out_t mk_result(input int r, input int c, input logic [15:0] d);
    tcw_out_t res;
    res.cursor_row_out = ROW_W'(r);
    res.cursor_col_out = COL_W'(c);
    res.cell_data      = d;
    return res;
  endfunction

  task automatic add_row(input tcw_in_t item, input int reps, input bit typed,
                         input tcw_out_t want);
    dir_row_t row;
    row.item  = item;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    dir_table.push_back(row);
  endtask

  // Sender bursts: runs of back-to-back transfers separated by random gaps
  function automatic int next_gap();
    if (tx_steady) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 24);
    return $urandom_range(1, 9);
  endfunction

  // Drive one command and record its expected result on transfer
  task automatic send_cmd(input tcw_in_t item, input int gap, input bit typed,
                          input tcw_out_t want);
    tcw_out_t pred;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = console_step(item);
    result_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic apply_color(input logic [7:0] color);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_color = color;
  endtask

  // Queue one random command sequence: mostly text lines, newline runs and reads
  task automatic build_sequence();
    int kind;
    int len;
    logic [7:0] ch;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
      repeat (len) begin
        ch = 8'($urandom);
        cmd_stream.push_back(mk_cmd(CMD_PUT, ch, 5'($urandom), 7'($urandom)));
      end
      if ($urandom_range(0, 9) < 7)
        cmd_stream.push_back(mk_cmd(CMD_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom)));
    end else if (kind < 60) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      repeat (len)
        cmd_stream.push_back(mk_cmd(CMD_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom)));
    end else if (kind < 85) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        if ($urandom_range(0, 6) == 0)
          cmd_stream.push_back(mk_cmd(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom)));
        else
          cmd_stream.push_back(mk_cmd(CMD_READ, 8'($urandom), 5'($urandom_range(0, ROWS_N - 1)),
                                      7'($urandom_range(0, COLS - 1))));
      end
    end else if (kind < 89) begin
      cmd_stream.push_back(mk_cmd(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len)
        cmd_stream.push_back(mk_cmd(tcw_cmd_t'(2'($urandom)), 8'($urandom), 5'($urandom),
                                    7'($urandom)));
    end
  endtask

  // Receiver: alternate ready runs and stalls, or stay ready in steady phases
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_stall = !rx_stall && !rx_steady && ($urandom_range(0, 2) != 0);
      rx_left  = rx_stall ? $urandom_range(1, 40) : $urandom_range(1, 25);
    end else begin
      rx_left--;
    end
    out_ready <= !rx_stall;
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        note_error($sformatf("unexpected result row %0d col %0d cell %h",
                             out_data.cursor_row_out, out_data.cursor_col_out,
                             out_data.cell_data));
      end else begin
        mon_want = result_q.pop_front();
        if (out_data.cursor_row_out !== mon_want.cursor_row_out)
          note_error($sformatf("cursor_row_out %0d, expected %0d",
                               out_data.cursor_row_out, mon_want.cursor_row_out));
        if (out_data.cursor_col_out !== mon_want.cursor_col_out)
          note_error($sformatf("cursor_col_out %0d, expected %0d",
                               out_data.cursor_col_out, mon_want.cursor_col_out));
        if (out_data.cell_data !== mon_want.cell_data)
          note_error($sformatf("cell_data %h, expected %h",
                               out_data.cell_data, mon_want.cell_data));
      end
    end
  end

  initial begin
    logic [7:0] colors [5];
    tcw_in_t item;
    int sent;
    int pause_at;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    err_count   = 0;
    cycle_count = 0;
    burst_left  = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_stall    = 1'b0;
    rx_left     = 0;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
    cur_row   = 0;
    cur_col   = 0;
    cur_color = COLOR_RESET;

    // Directed table: reset state, field extremes, every command, wrap and scroll
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd0, 7'd0), 1, 1, mk_result(0, 0, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd24, 7'd79), 1, 1, mk_result(0, 0, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'hFF, 5'd31, 7'd127), 1, 1, mk_result(0, 0, 16'h0000));
    add_row(mk_cmd(CMD_NONE, 8'hFF, 5'd31, 7'd127), 1, 1, mk_result(0, 0, 16'h0000));
    add_row(mk_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0), 1, 1, mk_result(0, 1, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd0, 7'd0), 1, 1, mk_result(0, 1, 16'h0741));
    add_row(mk_cmd(CMD_PUT, 8'hFF, 5'd31, 7'd127), 1, 0, '0);
    add_row(mk_cmd(CMD_PUT, 8'h00, 5'd0, 7'd0), 1, 0, '0);
    add_row(mk_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0), 1, 1, mk_result(1, 0, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd0, 7'd1), 1, 0, '0);
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd1, 7'd0), 1, 1, mk_result(1, 0, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd0, 7'd80), 1, 1, mk_result(1, 0, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd25, 7'd0), 1, 1, mk_result(1, 0, 16'h0000));
    add_row(mk_cmd(CMD_NONE, 8'h00, 5'd0, 7'd0), 1, 1, mk_result(1, 0, 16'h0000));
    add_row(mk_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0), 1, 1, mk_result(0, 0, 16'h0000));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd24, 7'd79), 1, 1, mk_result(0, 0, 16'h0720));
    add_row(mk_cmd(CMD_PUT, 8'h5A, 5'd0, 7'd0), 80, 0, '0);
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd0, 7'd79), 1, 1, mk_result(1, 0, 16'h075A));
    add_row(mk_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0), 24, 0, '0);
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd24, 7'd0), 1, 1, mk_result(24, 0, 16'h0720));
    add_row(mk_cmd(CMD_READ, 8'h00, 5'd0, 7'd0), 1, 0, '0);

    // Hold reset, then release on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      repeat (dir_table[i].reps)
        send_cmd(dir_table[i].item, next_gap(), dir_table[i].typed && dir_table[i].reps == 1,
                 dir_table[i].want);
    end

    // Random phases, each under its own text color
    colors[0] = 8'h00;
    colors[1] = 8'hFF;
    colors[2] = 8'($urandom);
    colors[3] = 8'h1E;
    colors[4] = COLOR_RESET;
    foreach (colors[ph]) begin
      apply_color(colors[ph]);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      pause_at  = $urandom_range(20, PHASE_ITEMS - 20);
      sent      = 0;
      cmd_stream.delete();
      while (sent < PHASE_ITEMS) begin
        if (cmd_stream.size() == 0) build_sequence();
        item = cmd_stream.pop_front();
        if (sent == pause_at) wait_drained();
        send_cmd(item, next_gap(), 1'b0, '0);
        sent++;
      end
    end

    // Drain and let any stray result show up
    wait_drained();
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_cell_store.sv
rtl/core/text_console_writer.sv
tb/sv/tb_top.sv
